/* sv/qesm_pkg.sv */
`default_nettype none

package qesm_pkg;

  // Output field and averaging widths
  localparam int SPEED_W = 29;
  localparam int SUM_W   = SPEED_W + 2;
  localparam int CFG_W   = 16;

  // Largest positive speed in Q8
  localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

  // Configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_EDGES   = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd45000;
  localparam logic [CFG_W-1:0] EDGES_RST   = 16'd480;

  typedef struct packed {
    logic a_level;
    logic b_level;
    logic report;
  } in_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_q8;
    logic                      motor_stopped;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_SAMP,
    ST_HIST,
    ST_SUM,
    ST_ROUND,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* sv/quadrature_encoder_speed_meter_unit.sv */
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------
// in       | input     | in_valid_i/in_ready_o | in_i: a_level, b_level, report
// out      | output    | out_valid_o/out_ready_i | out_o: speed_q8, motor_stopped
// cfg      | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// An item without report leaves the unit idle, so the next can follow at once.
// A report item passes through the accept cycle, multiply, divider setup, one
// restoring divider step per quotient bit, sample, history, four accumulate
// steps, rounding and the output load.
// A zero period skips the divide. A report while stopped goes straight to the output load.
// Reset loads the configuration defaults, clears tick count and history, and marks the motor stopped.
// The result waits in an output register; a stalled output holds the block in
// its final state only until that register frees up.
module quadrature_encoder_speed_meter_unit #(
  parameter int TICK_HZ    = 1000000,
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire qesm_pkg::in_t                in_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output qesm_pkg::out_t                    out_o,
  input  wire                               cfg_we_i,
  input  wire                               cfg_idx_i,
  input  wire [qesm_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int CFG_W  = qesm_pkg::CFG_W;
  localparam int SPD_W  = qesm_pkg::SPEED_W;
  localparam int SUM_W  = qesm_pkg::SUM_W;
  localparam int DEN_W  = CFG_W + COUNT_BITS;
  localparam int TICK_W = $clog2(TICK_HZ + 1);
  localparam int NUM_MAX = (TICK_W + FRAC_BITS > DEN_W) ? TICK_W + FRAC_BITS : DEN_W;
  localparam int NUM_W  = NUM_MAX + 1;
  localparam int QW     = (NUM_W > SPD_W) ? NUM_W : SPD_W;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int CMP_W  = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [NUM_W-1:0] NUM_CONST = NUM_W'(TICK_HZ) << FRAC_BITS;

  // Configuration
  logic [CFG_W-1:0] timeout_q, edges_q;

  // Tick tracking state
  logic                  prev_a_q, prev_b_q;
  logic [COUNT_BITS-1:0] tick_q;
  logic                  per_neg_q;
  logic [COUNT_BITS-1:0] per_mag_q;
  logic                  stopped_q;

  // Sequencer and shared datapath
  qesm_pkg::state_e state_q, state_d;
  logic [DEN_W-1:0]          den_q;
  logic [DEN_W-1:0]          rem_q;
  logic [NUM_W-1:0]          nq_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [SPD_W-1:0]   sample_q;
  logic signed [SPD_W-1:0]   hist_q [4];
  logic signed [SUM_W-1:0]   acc_q;
  logic [1:0]                idx_q;
  logic signed [SPD_W-1:0]   speed_q;
  logic                      last_nz_q;
  logic                      out_valid_q;
  qesm_pkg::out_t            out_q;

  // Control
  logic accept, is_report, slot_free;

  // Per-tick edge handling
  logic                  a_edge, b_edge, any_edge;
  logic [COUNT_BITS-1:0] tick_new;
  logic                  stopped_new;

  // Divider step
  logic [DEN_W:0] trial, diff;
  logic           ge;

  // Saturation and rounding
  logic [QW-1:0]          q_ext;
  logic [SPD_W-1:0]       q_mag;
  logic [SUM_W-1:0]       acc_abs;
  logic [SUM_W-1:0]       acc_rnd;

  assign accept    = in_valid_i && in_ready_o;
  assign is_report = in_i.report;
  assign slot_free = !out_valid_q || out_ready_i;

  // Edges against previous levels, saturating count, stop flag
  always_comb begin
    a_edge   = in_i.a_level != prev_a_q;
    b_edge   = in_i.b_level != prev_b_q;
    any_edge = a_edge || b_edge;
    if (any_edge) begin
      tick_new = '0;
    end else if (tick_q != {COUNT_BITS{1'b1}}) begin
      tick_new = tick_q + COUNT_BITS'(1);
    end else begin
      tick_new = tick_q;
    end
    stopped_new = any_edge ? 1'b0 : stopped_q;
    if (is_report && (CMP_W'(tick_new) > CMP_W'(timeout_q))) begin
      stopped_new = 1'b1;
    end
  end

  // Restoring divider step
  always_comb begin
    trial = {rem_q, nq_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  // Quotient saturation and average rounding
  always_comb begin
    q_ext   = QW'(nq_q);
    q_mag   = (q_ext > QW'(qesm_pkg::SPEED_MAX)) ? qesm_pkg::SPEED_MAX : q_ext[SPD_W-1:0];
    acc_abs = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
    acc_rnd = (acc_abs + SUM_W'(2)) >> 2;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qesm_pkg::ST_IDLE: begin
        if (accept && is_report) begin
          state_d = stopped_new ? qesm_pkg::ST_DONE : qesm_pkg::ST_MUL;
        end
      end
      qesm_pkg::ST_MUL:  state_d = qesm_pkg::ST_PREP;
      qesm_pkg::ST_PREP: begin
        state_d = (den_q == '0) ? qesm_pkg::ST_SAMP : qesm_pkg::ST_DIV;
      end
      qesm_pkg::ST_DIV: begin
        if (cnt_q == CNT_W'(NUM_W - 1)) state_d = qesm_pkg::ST_SAMP;
      end
      qesm_pkg::ST_SAMP: state_d = qesm_pkg::ST_HIST;
      qesm_pkg::ST_HIST: state_d = qesm_pkg::ST_SUM;
      qesm_pkg::ST_SUM: begin
        if (idx_q == 2'd3) state_d = qesm_pkg::ST_ROUND;
      end
      qesm_pkg::ST_ROUND: state_d = qesm_pkg::ST_DONE;
      qesm_pkg::ST_DONE: begin
        if (slot_free) state_d = qesm_pkg::ST_IDLE;
      end
      default: state_d = qesm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = state_q == qesm_pkg::ST_IDLE;
    out_valid_o = out_valid_q;
    out_o       = out_q;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= qesm_pkg::TIMEOUT_RST;
      edges_q   <= qesm_pkg::EDGES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qesm_pkg::REG_TIMEOUT: timeout_q <= cfg_data_i;
        qesm_pkg::REG_EDGES:   edges_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tick state, updated on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q  <= 1'b1;
      prev_b_q  <= 1'b1;
      tick_q    <= '0;
      per_neg_q <= 1'b0;
      per_mag_q <= '0;
      stopped_q <= 1'b1;
    end else if (accept) begin
      prev_a_q  <= in_i.a_level;
      prev_b_q  <= in_i.b_level;
      tick_q    <= tick_new;
      stopped_q <= stopped_new;
      // A rule runs after the B rule, with the count already cleared by B
      if (a_edge && (in_i.a_level == in_i.b_level)) begin
        per_neg_q <= 1'b0;
        per_mag_q <= b_edge ? '0 : tick_q;
      end else if (b_edge && (in_i.a_level == in_i.b_level)) begin
        per_neg_q <= 1'b1;
        per_mag_q <= tick_q;
      end
    end
  end

  // Sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qesm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      last_nz_q   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // Load a finished result, else drop the one just taken
      if ((state_q == qesm_pkg::ST_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
        last_nz_q   <= speed_q != '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        qesm_pkg::ST_HIST: begin
          // Refill after a zero speed, else shift the new sample in
          if (!last_nz_q) begin
            for (int i = 0; i < 4; i++) begin
              hist_q[i] <= sample_q;
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              hist_q[i] <= hist_q[i+1];
            end
            hist_q[3] <= sample_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      qesm_pkg::ST_IDLE: begin
        speed_q <= '0;
      end
      qesm_pkg::ST_MUL: begin
        den_q <= DEN_W'(edges_q) * DEN_W'(per_mag_q);
      end
      qesm_pkg::ST_PREP: begin
        rem_q <= '0;
        cnt_q <= '0;
        nq_q  <= (den_q == '0) ? '0 : NUM_CONST + NUM_W'(den_q >> 1);
      end
      qesm_pkg::ST_DIV: begin
        rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q  <= {nq_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      qesm_pkg::ST_SAMP: begin
        sample_q <= per_neg_q ? -$signed(q_mag) : $signed(q_mag);
      end
      qesm_pkg::ST_HIST: begin
        acc_q <= '0;
        idx_q <= '0;
      end
      qesm_pkg::ST_SUM: begin
        acc_q <= acc_q + SUM_W'(hist_q[idx_q]);
        idx_q <= idx_q + 2'd1;
      end
      qesm_pkg::ST_ROUND: begin
        speed_q <= acc_q[SUM_W-1] ? -$signed(acc_rnd[SPD_W-1:0])
                                  : $signed(acc_rnd[SPD_W-1:0]);
      end
      qesm_pkg::ST_DONE: begin
        if (slot_free) begin
          out_q.speed_q8      <= speed_q;
          out_q.motor_stopped <= stopped_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
